/* rtl/core/dkms_pkg.sv */
`default_nettype none

package dkms_pkg;

    localparam int unsigned PINS_MAX = 16;
    localparam int unsigned LEVEL_W  = 16;
    localparam int unsigned IDX_W    = 8;

    typedef enum logic [2:0] {
        REG_SCAN_ENABLE = 3'd0,
        REG_PIN_COUNT   = 3'd1,
        REG_SPLIT_POINT = 3'd2,
        REG_DEBOUNCE    = 3'd3,
        REG_POLL        = 3'd4
    } reg_idx_t;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic {
        KIND_DRIVE = 1'b0,
        KIND_KEY   = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROWS,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic        scan_enable;
        logic [4:0]  pin_count;
        logic [3:0]  split_point;
        logic [15:0] debounce_ticks;
        logic [15:0] poll_ticks;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [LEVEL_W-1:0] levels;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] drive_pin;
        logic       drive_on;
        logic [3:0] key_row;
        logic [3:0] key_col;
        logic       key_pressed;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/duplex_key_matrix_scanner.sv */
// duplex key-matrix scanner
// item channel (item_valid/item_stall): func 0 is one timer tick, func 1 is the
// sense sample for the pin currently driven; sense_levels bit i is pin i.
// result channel (result_valid/result_stall): drive updates (kind 0) and key
// change events (kind 1); last marks the final result of an item.
// apb port: scan_enable, pin_count, split_point, debounce_ticks, poll_ticks at
// byte addresses 0, 4, 8, 12, 16; the user writes them only while the block is
// idle, which the block does not enforce. a two-entry queue takes items while
// earlier ones are still being worked on; a tick's result is registered.
// a sample walks its sense rows through the key store one row per cycle, save
// while a key event waits on a stalled result; rows are the sense pins of the
// pass (up to 15), with one event per changed key and a closing drive update.
// after reset the key store is swept to zero, during which item_stall is high;
// config writes are taken as always. a stalled result holds in the output
// register; work stops behind it and the queue fills, then item_stall rises.
`default_nettype none

module duplex_key_matrix_scanner #(
    parameter int unsigned MAX_KEYS = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        func,
    input  wire logic [15:0] sense_levels,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             kind,
    output logic      [3:0]  drive_pin,
    output logic             drive_on,
    output logic      [3:0]  key_row,
    output logic      [3:0]  key_col,
    output logic             key_pressed,
    output logic             last
);

    dkms_pkg::cfg_t     cfg_reg, cfg_next;
    dkms_pkg::reg_idx_t reg_idx;
    logic               cfg_write;
    logic               en_rise;
    logic               clearing;
    logic               q_valid;
    logic               q_pop;
    dkms_pkg::item_t    q_item;
    dkms_pkg::result_t  res;

    assign pready    = 1'b1;
    assign reg_idx   = dkms_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign en_rise   = cfg_write && (reg_idx == dkms_pkg::REG_SCAN_ENABLE) &&
                       pwdata[0] && !cfg_reg.scan_enable;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                dkms_pkg::REG_SCAN_ENABLE: cfg_next.scan_enable    = pwdata[0];
                dkms_pkg::REG_PIN_COUNT:   cfg_next.pin_count      = pwdata[4:0];
                dkms_pkg::REG_SPLIT_POINT: cfg_next.split_point    = pwdata[3:0];
                dkms_pkg::REG_DEBOUNCE:    cfg_next.debounce_ticks = pwdata[15:0];
                dkms_pkg::REG_POLL:        cfg_next.poll_ticks     = pwdata[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dkms_pkg::REG_SCAN_ENABLE: prdata = {31'd0, cfg_reg.scan_enable};
            dkms_pkg::REG_PIN_COUNT:   prdata = {27'd0, cfg_reg.pin_count};
            dkms_pkg::REG_SPLIT_POINT: prdata = {28'd0, cfg_reg.split_point};
            dkms_pkg::REG_DEBOUNCE:    prdata = {16'd0, cfg_reg.debounce_ticks};
            dkms_pkg::REG_POLL:        prdata = {16'd0, cfg_reg.poll_ticks};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_enable    <= 1'b0;
            cfg_reg.pin_count      <= 5'd16;
            cfg_reg.split_point    <= 4'd8;
            cfg_reg.debounce_ticks <= 16'd5;
            cfg_reg.poll_ticks     <= 16'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dkms_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .sense_levels (sense_levels),
        .clearing     (clearing),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    dkms_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .en_rise      (en_rise),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (res)
    );

    assign kind        = res.kind;
    assign drive_pin   = res.drive_pin;
    assign drive_on    = res.drive_on;
    assign key_row     = res.key_row;
    assign key_col     = res.key_col;
    assign key_pressed = res.key_pressed;
    assign last        = res.last;

endmodule

`default_nettype wire

/* rtl/core/dkms_ram.sv */
`default_nettype none

module dkms_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dkms_front.sv */
`default_nettype none

module dkms_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire logic           func,
    input  wire logic [dkms_pkg::LEVEL_W-1:0] sense_levels,
    input  wire logic           clearing,
    output logic                q_valid,
    output dkms_pkg::item_t     q_item,
    input  wire logic           q_pop
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dkms_pkg::item_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    dkms_pkg::item_t   push_item;

    // no transfer while the key store is being swept after reset
    assign item_stall = (count_reg == CNT_W'(DEPTH)) || clearing;
    assign push       = item_valid && !item_stall;

    always_comb
    begin
        push_item.op     = func ? dkms_pkg::OP_SAMPLE : dkms_pkg::OP_TICK;
        push_item.levels = sense_levels;
    end

    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != CNT_W'(DEPTH))
        else $error("transfer into a full queue");

endmodule

`default_nettype wire

/* rtl/core/dkms_back.sv */
`default_nettype none

module dkms_back #(
    parameter int unsigned MAX_KEYS = 128
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dkms_pkg::cfg_t  cfg,
    input  wire logic            en_rise,
    input  wire logic            q_valid,
    input  wire dkms_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output dkms_pkg::result_t    result
);

    localparam int unsigned AW    = $clog2(MAX_KEYS);
    localparam int unsigned IDX_W = dkms_pkg::IDX_W;

    dkms_pkg::state_t  state_reg, state_next;

    logic              scanning_reg, scanning_next;
    logic              pass_two_reg, pass_two_next;
    logic [3:0]        drive_index_reg, drive_index_next;
    logic [15:0]       wait_count_reg, wait_count_next;
    logic              change_seen_reg, change_seen_next;
    logic [dkms_pkg::LEVEL_W-1:0] levels_reg, levels_next;
    logic [3:0]        rd_row_reg, rd_row_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [3:0]        cmp_row_reg, cmp_row_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              out_valid_reg, out_valid_next;
    dkms_pkg::result_t out_reg, out_next;

    // geometry from the live registers and the current pass
    logic [4:0]        n_pins;
    logic [4:0]        split5;
    logic              geo_ok;
    logic [4:0]        n_minus_s;
    logic [4:0]        dcount;
    logic [4:0]        scount;
    logic [3:0]        sense_base;
    logic [3:0]        row_base;
    logic [3:0]        pin_base;
    logic [IDX_W-1:0]  pass_prod;
    logic [IDX_W-1:0]  key_offset;
    logic [4:0]        di_inc;
    logic              rows_needed;

    logic              out_free;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [0:0]        ram_wdata;
    logic [0:0]        ram_rdata;
    logic [3:0]        cmp_pin;
    logic              cmp_lvl;
    logic              cmp_in_range;
    logic              need_event;
    logic              rows_go;
    logic              rd_more;

    assign n_pins     = (cfg.pin_count > 5'(dkms_pkg::PINS_MAX)) ?
                        5'(dkms_pkg::PINS_MAX) : cfg.pin_count;
    assign split5     = {1'b0, cfg.split_point};
    assign geo_ok     = (cfg.split_point != 4'd0) && (split5 < n_pins);
    assign n_minus_s  = n_pins - split5;
    assign dcount     = pass_two_reg ? n_minus_s : split5;
    assign scount     = pass_two_reg ? split5 : n_minus_s;
    assign sense_base = pass_two_reg ? 4'd0 : cfg.split_point;
    assign row_base   = pass_two_reg ? n_minus_s[3:0] : 4'd0;
    assign pin_base   = pass_two_reg ? cfg.split_point : 4'd0;
    assign pass_prod  = IDX_W'({4'd0, cfg.split_point} * {4'd0, n_minus_s[3:0]});
    assign key_offset = pass_two_reg ? pass_prod : '0;
    assign di_inc     = {1'b0, drive_index_reg} + 5'd1;
    assign rows_needed = geo_ok && ({1'b0, drive_index_reg} < dcount);

    assign out_free     = !out_valid_reg || !result_stall;
    assign cmp_pin      = sense_base + cmp_row_reg;
    assign cmp_lvl      = levels_reg[cmp_pin];
    assign cmp_in_range = 32'(cmp_idx_reg) < MAX_KEYS;
    assign need_event   = cmp_vld_reg && cmp_in_range && (ram_rdata[0] != cmp_lvl);
    assign rows_go      = !need_event || out_free;
    assign rd_more      = {1'b0, rd_row_reg} < scount;

    assign q_pop        = (state_reg == dkms_pkg::ST_IDLE) && q_valid && out_free;
    assign clearing     = (state_reg == dkms_pkg::ST_CLEAR);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    dkms_ram #(
        .WIDTH (1),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (AW'(rd_idx_reg)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dkms_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(MAX_KEYS - 1))
                begin
                    state_next = dkms_pkg::ST_IDLE;
                end
            end
            dkms_pkg::ST_IDLE:
            begin
                if (q_pop && q_item.op == dkms_pkg::OP_SAMPLE && scanning_reg)
                begin
                    state_next = rows_needed ? dkms_pkg::ST_ROWS : dkms_pkg::ST_FINAL;
                end
            end
            dkms_pkg::ST_ROWS:
            begin
                if (rows_go && !rd_more)
                begin
                    state_next = dkms_pkg::ST_FINAL;
                end
            end
            dkms_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = dkms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dkms_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        scanning_next    = scanning_reg;
        pass_two_next    = pass_two_reg;
        drive_index_next = drive_index_reg;
        wait_count_next  = wait_count_reg;
        change_seen_next = change_seen_reg;
        levels_next      = levels_reg;
        rd_row_next      = rd_row_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        cmp_row_next     = cmp_row_reg;
        cmp_idx_next     = cmp_idx_reg;
        clr_addr_next    = clr_addr_reg;
        out_valid_next   = out_valid_reg && result_stall;
        out_next         = out_reg;
        ram_we           = 1'b0;
        ram_waddr        = AW'(cmp_idx_reg);
        ram_wdata        = cmp_lvl;
        ram_re           = 1'b0;

        unique case (state_reg)
            dkms_pkg::ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = 1'b0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            dkms_pkg::ST_IDLE:
            begin
                if (q_pop && q_item.op == dkms_pkg::OP_TICK && !scanning_reg)
                begin
                    if (wait_count_reg > 16'd1)
                    begin
                        wait_count_next = wait_count_reg - 16'd1;
                    end
                    else
                    begin
                        wait_count_next = '0;
                        if (cfg.scan_enable)
                        begin
                            change_seen_next  = 1'b0;
                            pass_two_next     = 1'b0;
                            drive_index_next  = '0;
                            out_valid_next    = 1'b1;
                            out_next          = '0;
                            out_next.kind     = dkms_pkg::KIND_DRIVE;
                            out_next.last     = 1'b1;
                            if (geo_ok)
                            begin
                                scanning_next     = 1'b1;
                                out_next.drive_on = 1'b1;
                            end
                            else
                            begin
                                // no keys: release at once and wait a poll period
                                wait_count_next = cfg.poll_ticks;
                            end
                        end
                    end
                end
                else if (q_pop && q_item.op == dkms_pkg::OP_SAMPLE && scanning_reg)
                begin
                    levels_next  = q_item.levels;
                    rd_row_next  = '0;
                    rd_idx_next  = key_offset + IDX_W'(drive_index_reg);
                    cmp_vld_next = 1'b0;
                end
            end
            dkms_pkg::ST_ROWS:
            begin
                if (rows_go)
                begin
                    // read row r while row r-1 is compared
                    if (rd_more)
                    begin
                        ram_re       = 1'b1;
                        cmp_vld_next = 1'b1;
                        cmp_row_next = rd_row_reg;
                        cmp_idx_next = rd_idx_reg;
                        rd_row_next  = rd_row_reg + 4'd1;
                        rd_idx_next  = rd_idx_reg + IDX_W'(dcount);
                    end
                    else
                    begin
                        cmp_vld_next = 1'b0;
                    end
                    if (need_event)
                    begin
                        ram_we               = 1'b1;
                        change_seen_next     = 1'b1;
                        out_valid_next       = 1'b1;
                        out_next             = '0;
                        out_next.kind        = dkms_pkg::KIND_KEY;
                        out_next.key_row     = row_base + cmp_row_reg;
                        out_next.key_col     = drive_index_reg;
                        out_next.key_pressed = cmp_lvl;
                    end
                end
            end
            dkms_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.kind  = dkms_pkg::KIND_DRIVE;
                    out_next.last  = 1'b1;
                    if (geo_ok && di_inc < dcount)
                    begin
                        drive_index_next   = di_inc[3:0];
                        out_next.drive_pin = pin_base + di_inc[3:0];
                        out_next.drive_on  = 1'b1;
                    end
                    else if (geo_ok && !pass_two_reg)
                    begin
                        pass_two_next      = 1'b1;
                        drive_index_next   = '0;
                        out_next.drive_pin = cfg.split_point;
                        out_next.drive_on  = 1'b1;
                    end
                    else
                    begin
                        scanning_next    = 1'b0;
                        pass_two_next    = 1'b0;
                        drive_index_next = '0;
                        wait_count_next  = change_seen_reg ? cfg.debounce_ticks :
                                                             cfg.poll_ticks;
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase

        // enabling from idle makes the next tick scan
        if (en_rise && !scanning_reg)
        begin
            wait_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dkms_pkg::ST_CLEAR;
            scanning_reg    <= 1'b0;
            pass_two_reg    <= 1'b0;
            drive_index_reg <= '0;
            wait_count_reg  <= '0;
            change_seen_reg <= 1'b0;
            rd_row_reg      <= '0;
            cmp_vld_reg     <= 1'b0;
            clr_addr_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scanning_reg    <= scanning_next;
            pass_two_reg    <= pass_two_next;
            drive_index_reg <= drive_index_next;
            wait_count_reg  <= wait_count_next;
            change_seen_reg <= change_seen_next;
            rd_row_reg      <= rd_row_next;
            cmp_vld_reg     <= cmp_vld_next;
            clr_addr_reg    <= clr_addr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        levels_reg  <= levels_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_row_reg <= cmp_row_next;
        cmp_idx_reg <= cmp_idx_next;
        out_reg     <= out_next;
    end

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dkms_pkg::ST_CLEAR |-> !scanning_reg && !out_valid_reg)
        else $error("activity during key store sweep");

    a_key_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == dkms_pkg::KIND_KEY |-> !out_reg.last)
        else $error("key event marked as final result");

    a_drive_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == dkms_pkg::KIND_DRIVE && out_reg.drive_on
        |-> scanning_reg)
        else $error("pin driven outside a scan");

endmodule

`default_nettype wire

/* verif/duplex_key_matrix_scanner_tb.sv */
`timescale 1ns / 1ps

module duplex_key_matrix_scanner_tb;

    localparam int unsigned KEY_SLOTS    = 128;
    localparam int unsigned EVENTS_MAX   = 15;
    localparam int unsigned TARGET_ITEMS = 280;
    localparam int unsigned SETTLE_GAP   = 40;
    localparam int unsigned QUIET_LIMIT  = 4000;

    typedef enum int {
        BY_MODEL,
        TYPED_NONE,
        TYPED_ONE
    } check_mode_t;

    typedef struct {
        bit                 is_write;
        dkms_pkg::reg_idx_t reg_sel;
        logic [31:0]        value;
        dkms_pkg::op_t      op;
        logic [15:0]        levels;
        check_mode_t        mode;
        dkms_pkg::result_t  want;
    } plan_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [4:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic        func         = 1'b0;
    logic [15:0] sense_levels = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        kind;
    logic [3:0]  drive_pin;
    logic        drive_on;
    logic [3:0]  key_row;
    logic [3:0]  key_col;
    logic        key_pressed;
    logic        last;

    duplex_key_matrix_scanner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .sense_levels (sense_levels),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .drive_pin    (drive_pin),
        .drive_on     (drive_on),
        .key_row      (key_row),
        .key_col      (key_col),
        .key_pressed  (key_pressed),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scanner state as the block should hold it
    logic        cfg_enable;
    logic [4:0]  cfg_pins;
    logic [3:0]  cfg_split;
    logic [15:0] cfg_debounce;
    logic [15:0] cfg_poll;
    logic        key_state [KEY_SLOTS];
    bit          scan_busy;
    bit          second_pass;
    int unsigned drive_idx;
    logic [15:0] wait_left;
    bit          saw_change;

    dkms_pkg::result_t step_results [$];
    dkms_pkg::result_t results_due [$];
    plan_row_t         plan [$];

    int unsigned fails       = 0;
    int unsigned acted       = 0;
    int unsigned burst_left  = 0;
    bit          dirty       = 1'b0;
    int unsigned quiet       = 0;

    function automatic dkms_pkg::result_t make_result(dkms_pkg::kind_t k, int unsigned pin,
                                                      bit on, int unsigned row,
                                                      int unsigned col, bit pressed, bit fin);
        dkms_pkg::result_t r;
        r.kind        = k;
        r.drive_pin   = pin[3:0];
        r.drive_on    = on;
        r.key_row     = row[3:0];
        r.key_col     = col[3:0];
        r.key_pressed = pressed;
        r.last        = fin;
        return r;
    endfunction

    function automatic int unsigned pins_in_use();
        return (cfg_pins > 5'd16) ? 16 : int'(cfg_pins);
    endfunction

    function automatic bit geometry_ok();
        return cfg_split >= 4'd1 && int'(cfg_split) < pins_in_use();
    endfunction

    function automatic void matrix_reset();
        cfg_enable   = 1'b0;
        cfg_pins     = 5'd16;
        cfg_split    = 4'd8;
        cfg_debounce = 16'd5;
        cfg_poll     = 16'd10;
        foreach (key_state[i])
            key_state[i] = 1'b0;
        scan_busy    = 1'b0;
        second_pass  = 1'b0;
        drive_idx    = 0;
        wait_left    = '0;
        saw_change   = 1'b0;
    endfunction

    function automatic void matrix_config(dkms_pkg::reg_idx_t idx, logic [31:0] v);
        case (idx)
            dkms_pkg::REG_SCAN_ENABLE:
            begin
                // rising enable restarts the countdown
                if (v[0] && !cfg_enable && !scan_busy)
                    wait_left = '0;
                cfg_enable = v[0];
            end
            dkms_pkg::REG_PIN_COUNT:   cfg_pins     = v[4:0];
            dkms_pkg::REG_SPLIT_POINT: cfg_split    = v[3:0];
            dkms_pkg::REG_DEBOUNCE:    cfg_debounce = v[15:0];
            dkms_pkg::REG_POLL:        cfg_poll     = v[15:0];
            default: ;
        endcase
    endfunction

    function automatic void close_scan();
        scan_busy   = 1'b0;
        second_pass = 1'b0;
        drive_idx   = 0;
        wait_left   = saw_change ? cfg_debounce : cfg_poll;
        step_results.push_back(make_result(dkms_pkg::KIND_DRIVE, 0, 0, 0, 0, 0, 0));
    endfunction

    function automatic void tick_step();
        if (scan_busy)
            return;
        if (wait_left > 16'd1)
        begin
            wait_left = wait_left - 16'd1;
            return;
        end
        wait_left = '0;
        if (!cfg_enable)
            return;
        saw_change  = 1'b0;
        second_pass = 1'b0;
        drive_idx   = 0;
        if (!geometry_ok())
        begin
            close_scan();
            return;
        end
        scan_busy = 1'b1;
        step_results.push_back(make_result(dkms_pkg::KIND_DRIVE, 0, 1, 0, 0, 0, 0));
    endfunction

    function automatic void sense_step(logic [15:0] lv);
        int unsigned n;
        int unsigned s;
        int unsigned sense_cnt;
        int unsigned sense_base;
        int unsigned key_base;
        int unsigned row_base;
        int unsigned drv_cnt;
        int unsigned idx;
        int unsigned pin;
        int unsigned events;
        int unsigned r;
        bit          geo;
        n       = pins_in_use();
        s       = int'(cfg_split);
        geo     = geometry_ok();
        drv_cnt = 0;
        events  = 0;
        if (!scan_busy)
            return;
        if (geo)
        begin
            sense_cnt  = second_pass ? s : n - s;
            sense_base = second_pass ? 0 : s;
            key_base   = second_pass ? s * (n - s) : 0;
            row_base   = second_pass ? n - s : 0;
            drv_cnt    = second_pass ? n - s : s;
            if (drive_idx < drv_cnt)
            begin
                for (r = 0; r < sense_cnt; r++)
                begin
                    pin = sense_base + r;
                    idx = key_base + r * drv_cnt + drive_idx;
                    if (idx < KEY_SLOTS && key_state[idx] != lv[pin]
                        && events < EVENTS_MAX)
                    begin
                        key_state[idx] = lv[pin];
                        saw_change     = 1'b1;
                        step_results.push_back(make_result(dkms_pkg::KIND_KEY, 0, 0,
                                                           row_base + r, drive_idx,
                                                           lv[pin], 0));
                        events++;
                    end
                end
            end
        end
        drive_idx++;
        if (geo && drive_idx < drv_cnt)
            step_results.push_back(make_result(dkms_pkg::KIND_DRIVE,
                                               (second_pass ? s : 0) + drive_idx,
                                               1, 0, 0, 0, 0));
        else if (geo && !second_pass)
        begin
            second_pass = 1'b1;
            drive_idx   = 0;
            step_results.push_back(make_result(dkms_pkg::KIND_DRIVE, s, 1, 0, 0, 0, 0));
        end
        else
            close_scan();
    endfunction

    function automatic void matrix_step(dkms_pkg::op_t op, logic [15:0] lv);
        step_results.delete();
        if (op == dkms_pkg::OP_SAMPLE)
            sense_step(lv);
        else
            tick_step();
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void plan_write(dkms_pkg::reg_idx_t idx, logic [31:0] v);
        plan_row_t p;
        p.is_write = 1'b1;
        p.reg_sel  = idx;
        p.value    = v;
        p.op       = dkms_pkg::OP_TICK;
        p.levels   = '0;
        p.mode     = TYPED_NONE;
        p.want     = '0;
        plan.push_back(p);
    endfunction

    function automatic void plan_item(dkms_pkg::op_t op, logic [15:0] lv, check_mode_t mode,
                                      dkms_pkg::result_t want);
        plan_row_t p;
        p.is_write = 1'b0;
        p.reg_sel  = dkms_pkg::REG_SCAN_ENABLE;
        p.value    = '0;
        p.op       = op;
        p.levels   = lv;
        p.mode     = mode;
        p.want     = want;
        plan.push_back(p);
    endfunction

    // hold items back until every expected result is out
    task automatic settle(bit with_gap);
        item_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        if (with_gap)
            repeat (SETTLE_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic reg_write(dkms_pkg::reg_idx_t idx, logic [31:0] v);
        if (dirty)
        begin
            settle(1'b1);
            dirty = 1'b0;
        end
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        matrix_config(idx, v);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(dkms_pkg::op_t op, logic [15:0] lv, check_mode_t mode,
                             dkms_pkg::result_t want);
        if (burst_left == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
        item_valid   = 1'b1;
        func         = op;
        sense_levels = lv;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        matrix_step(op, lv);
        acted++;
        case (mode)
            BY_MODEL:   foreach (step_results[i]) results_due.push_back(step_results[i]);
            TYPED_ONE:  results_due.push_back(want);
            default: ;
        endcase
        dirty = 1'b1;
        @(negedge clk);
    endtask

    // receiver stall pattern: free running, random, or long holds
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    bit          hold_on    = 1'b0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
            0: result_stall = 1'b0;
            1: result_stall = ($urandom_range(0, 2) == 0);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_on   = !hold_on;
                    hold_left = hold_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                hold_left--;
                result_stall = hold_on;
            end
        endcase
    end

    function automatic void check_field(string name, logic [3:0] want_v, logic [3:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin
        dkms_pkg::result_t want;
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with nothing pending: kind %0d pin %0d on %0d row %0d col %0d",
                       kind, drive_pin, drive_on, key_row, key_col);
                fails++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("kind", want.kind, kind);
                check_field("drive_pin", want.drive_pin, drive_pin);
                check_field("drive_on", want.drive_on, drive_on);
                check_field("key_row", want.key_row, key_row);
                check_field("key_col", want.key_col, key_col);
                check_field("key_pressed", want.key_pressed, key_pressed);
                check_field("last", want.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (psel && penable && pready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("duplex_key_matrix_scanner_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        dkms_pkg::result_t none_r;
        dkms_pkg::result_t start_r;
        dkms_pkg::result_t release_r;
        dkms_pkg::op_t     op;
        logic [15:0]       lv;
        logic [15:0]       prev_lv;
        int unsigned       budget;
        int unsigned       sent;
        int unsigned       pc;
        int unsigned       pu;
        bit                en;

        none_r    = '0;
        start_r   = make_result(dkms_pkg::KIND_DRIVE, 0, 1, 0, 0, 0, 1);
        release_r = make_result(dkms_pkg::KIND_DRIVE, 0, 0, 0, 0, 0, 1);
        prev_lv   = '0;
        matrix_reset();

        // disabled tick, sample while idle
        plan_item(dkms_pkg::OP_TICK, 16'h0000, TYPED_NONE, none_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'hFFFF, TYPED_NONE, none_r);
        // three-pin matrix, one drive pin in the first pass
        plan_write(dkms_pkg::REG_PIN_COUNT, 32'd3);
        plan_write(dkms_pkg::REG_SPLIT_POINT, 32'd1);
        plan_write(dkms_pkg::REG_DEBOUNCE, 32'd2);
        plan_write(dkms_pkg::REG_POLL, 32'd65535);
        plan_write(dkms_pkg::REG_SCAN_ENABLE, 32'd1);
        plan_item(dkms_pkg::OP_TICK, 16'h0000, TYPED_ONE, start_r);
        plan_item(dkms_pkg::OP_TICK, 16'hFFFF, TYPED_NONE, none_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'hFFFF, BY_MODEL, none_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'h0000, BY_MODEL, none_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'h0001, BY_MODEL, none_r);
        // debounce countdown then a scan releasing keys
        plan_item(dkms_pkg::OP_TICK, 16'h0000, TYPED_NONE, none_r);
        plan_item(dkms_pkg::OP_TICK, 16'h0000, TYPED_ONE, start_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'h0000, BY_MODEL, none_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'hFFFF, BY_MODEL, none_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'h0000, BY_MODEL, none_r);
        plan_item(dkms_pkg::OP_TICK, 16'h0000, TYPED_NONE, none_r);
        plan_item(dkms_pkg::OP_TICK, 16'h0000, TYPED_ONE, start_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'h0000, BY_MODEL, none_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'h0000, BY_MODEL, none_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'h0000, BY_MODEL, none_r);
        // split of zero leaves no keys: release only, then the long poll wait
        plan_write(dkms_pkg::REG_SPLIT_POINT, 32'd0);
        plan_write(dkms_pkg::REG_SCAN_ENABLE, 32'd0);
        plan_write(dkms_pkg::REG_SCAN_ENABLE, 32'd1);
        plan_item(dkms_pkg::OP_TICK, 16'h0000, TYPED_ONE, release_r);
        plan_item(dkms_pkg::OP_TICK, 16'h0000, TYPED_NONE, none_r);
        // pin count beyond the matrix clamps to sixteen; fifteen keys change at once
        plan_write(dkms_pkg::REG_PIN_COUNT, 32'd31);
        plan_write(dkms_pkg::REG_SPLIT_POINT, 32'd1);
        plan_write(dkms_pkg::REG_DEBOUNCE, 32'd65535);
        plan_write(dkms_pkg::REG_SCAN_ENABLE, 32'd0);
        plan_write(dkms_pkg::REG_SCAN_ENABLE, 32'd1);
        plan_item(dkms_pkg::OP_TICK, 16'h0000, TYPED_ONE, start_r);
        plan_item(dkms_pkg::OP_SAMPLE, 16'hFFFF, BY_MODEL, none_r);

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_write)
                reg_write(plan[i].reg_sel, plan[i].value);
            else
                send_item(plan[i].op, plan[i].levels, plan[i].mode, plan[i].want);
        end

        while (acted < TARGET_ITEMS)
        begin
            en = ($urandom_range(0, 7) != 0);
            reg_write(dkms_pkg::REG_SCAN_ENABLE, 32'd0);
            if (en)
                reg_write(dkms_pkg::REG_SCAN_ENABLE, 32'd1);
            case ($urandom_range(0, 15))
                0:       pc = 2;
                1:       pc = 16;
                2:       pc = $urandom_range(17, 31);
                3:       pc = $urandom_range(0, 1);
                default: pc = $urandom_range(2, 16);
            endcase
            reg_write(dkms_pkg::REG_PIN_COUNT, pc);
            pu = (pc > 16) ? 16 : pc;
            case ($urandom_range(0, 15))
                0:       reg_write(dkms_pkg::REG_SPLIT_POINT, 32'd0);
                1:       reg_write(dkms_pkg::REG_SPLIT_POINT, $urandom_range(0, 15));
                2:       reg_write(dkms_pkg::REG_SPLIT_POINT, 32'd1);
                3:       reg_write(dkms_pkg::REG_SPLIT_POINT, 32'd15);
                default: reg_write(dkms_pkg::REG_SPLIT_POINT,
                                   (pu >= 2) ? $urandom_range(1, pu - 1) : 1);
            endcase
            case ($urandom_range(0, 9))
                0:       reg_write(dkms_pkg::REG_DEBOUNCE, 32'd65535);
                1:       reg_write(dkms_pkg::REG_DEBOUNCE, $urandom_range(0, 65535));
                default: reg_write(dkms_pkg::REG_DEBOUNCE, $urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 9))
                0:       reg_write(dkms_pkg::REG_POLL, 32'd65535);
                1:       reg_write(dkms_pkg::REG_POLL, $urandom_range(0, 65535));
                default: reg_write(dkms_pkg::REG_POLL, $urandom_range(1, 3));
            endcase

            budget = $urandom_range(10, 60);
            sent   = 0;
            while (acted < TARGET_ITEMS)
            begin
                // mostly well-formed: samples while a scan runs, ticks otherwise
                if (scan_busy)
                    op = ($urandom_range(0, 11) == 0) ? dkms_pkg::OP_TICK
                                                      : dkms_pkg::OP_SAMPLE;
                else
                    op = ($urandom_range(0, 11) == 0) ? dkms_pkg::OP_SAMPLE
                                                      : dkms_pkg::OP_TICK;
                case ($urandom_range(0, 9))
                    0:       lv = 16'h0000;
                    1:       lv = 16'hFFFF;
                    2, 3:    lv = prev_lv;
                    4, 5:    lv = prev_lv ^ (16'h0001 << $urandom_range(0, 15));
                    default: lv = 16'($urandom_range(0, 16'hFFFF));
                endcase
                send_item(op, lv, BY_MODEL, none_r);
                prev_lv = lv;
                sent++;
                if ($urandom_range(0, 24) == 0)
                    settle(1'b0);
                if (!scan_busy && wait_left > 16'd40)
                    break;
                if (sent >= budget && (!scan_busy || $urandom_range(0, 3) == 0))
                    break;
                if (sent >= 200)
                    break;
            end
        end

        settle(1'b1);
        if (fails == 0)
            $display("duplex_key_matrix_scanner_tb OK");
        else
            $display("duplex_key_matrix_scanner_tb NOT OK");
        $finish;
    end

endmodule
